@@ sv/vcp_pkg.sv @@
`default_nettype none

package vcp_pkg;

  // Request codes carried in the action field.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Special subchannel codes: "any" matches every subchannel, "none" never overrides.
  localparam logic signed [3:0] SUB_ANY  = -4'sd1;
  localparam logic signed [3:0] SUB_NONE = 4'sd0;

  // Starting value of the remaining-life search.
  localparam logic signed [31:0] LIFE_MAX = 32'sh7fff_ffff;

  // Reset value of the protected player entity.
  localparam logic [31:0] PLAYER_RESET = 32'd1;

  // One input beat.
  typedef struct packed {
    logic [1:0]        action;
    logic [31:0]       entity;
    logic signed [3:0] sub_channel;
    logic [30:0]       now_time;
    logic [23:0]       sound_length;
    logic              playable;
  } vcp_in_t;

  // One result beat.
  typedef struct packed {
    logic       found;
    logic [2:0] voice_index;
  } vcp_out_t;

  // One entry of the voice table.
  typedef struct packed {
    logic [31:0]       entity;
    logic signed [3:0] sub_channel;
    logic [31:0]       end_time;
    logic              active;
  } vcp_voice_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } vcp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic emit;
  } vcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } vcp_status_t;

endpackage

`default_nettype wire

@@ sv/vcp_ram.sv @@
`default_nettype none

module vcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output      logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/vcp_ctrl.sv @@
`default_nettype none

module vcp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      vcp_pkg::vcp_cmd_t   cmd_o,
  input  wire vcp_pkg::vcp_status_t status_i
);

  vcp_pkg::vcp_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      vcp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = vcp_pkg::ST_SCAN;
      end
      vcp_pkg::ST_SCAN: begin
        if (status_i.scan_done) state_d = vcp_pkg::ST_WRITE;
      end
      vcp_pkg::ST_WRITE: begin
        state_d = vcp_pkg::ST_FINISH;
      end
      vcp_pkg::ST_FINISH: begin
        if (slot_free) state_d = vcp_pkg::ST_IDLE;
      end
      default: begin
        state_d = vcp_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      vcp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      vcp_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      vcp_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
      end
      vcp_pkg::ST_FINISH: begin
        cmd_o.emit = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Result valid flag: set by emit, cleared when the beat leaves.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vcp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result only appears after a request has finished its write-back.
  a_valid_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == vcp_pkg::ST_FINISH))
    else $error("result valid rose outside the finish state");

endmodule

`default_nettype wire

@@ sv/vcp_datapath.sv @@
`default_nettype none

module vcp_datapath #(
  parameter int VOICES = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vcp_pkg::vcp_cmd_t    cmd_i,
  output      vcp_pkg::vcp_status_t status_o,
  input  wire vcp_pkg::vcp_in_t     in_data_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_data_i,
  output      vcp_pkg::vcp_out_t    out_data_o
);

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int IW = (AW > 3) ? AW : 3;
  localparam int VW = $bits(vcp_pkg::vcp_voice_t);

  // Request and configuration registers.
  vcp_pkg::vcp_in_t  item_q;
  vcp_pkg::vcp_out_t out_q, res_s;
  logic [31:0]       player_q;

  // Scan state.
  logic [CW-1:0]            rd_cnt_q, rd_cnt_d;
  logic                     ev_valid_q, ev_valid_d;
  logic [AW-1:0]            ev_idx_q, ev_idx_d;
  logic                     ev_vld_q, ev_vld_d;
  logic signed [31:0]       best_q, best_d;
  logic [AW-1:0]            pick_q, pick_d;
  logic                     pick_valid_q, pick_valid_d;
  logic                     hit_q, hit_d;
  logic [VOICES-1:0]        vld_q, vld_d;

  // Memory port signals.
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [VW-1:0]            rd_data;
  logic                     wr_en;
  logic [VW-1:0]            wr_data;
  vcp_pkg::vcp_voice_t      entry_s, new_voice;

  // Evaluation signals.
  logic                     is_start, is_stop;
  logic                     start_match, stop_match, skip_s;
  logic signed [31:0]       life_s;
  logic [IW-1:0]            pick_ext;
  logic                     found_s;

  assign is_start = (item_q.action == vcp_pkg::ACT_START);
  assign is_stop  = (item_q.action == vcp_pkg::ACT_STOP);

  // Read one voice per scan cycle until every voice has been issued.
  assign rd_en   = cmd_i.scan && (rd_cnt_q < CW'(VOICES));
  assign rd_addr = rd_cnt_q[AW-1:0];

  // An entry never written since reset or clear-all reads as zero.
  assign entry_s = ev_vld_q ? vcp_pkg::vcp_voice_t'(rd_data) : '0;

  // Matching rules for the voice under evaluation.
  assign start_match = (item_q.sub_channel != vcp_pkg::SUB_NONE) &&
                       (entry_s.entity == item_q.entity) &&
                       ((entry_s.sub_channel == item_q.sub_channel) ||
                        (item_q.sub_channel == vcp_pkg::SUB_ANY));
  assign stop_match  = (entry_s.entity == item_q.entity) &&
                       (entry_s.sub_channel == item_q.sub_channel);
  assign skip_s      = (entry_s.entity == player_q) && (item_q.entity != player_q) &&
                       entry_s.active;
  assign life_s      = $signed(entry_s.end_time - {1'b0, item_q.now_time});

  // Scan bookkeeping and selection.
  always_comb begin
    rd_cnt_d     = rd_cnt_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    ev_vld_d     = ev_vld_q;
    best_d       = best_q;
    pick_d       = pick_q;
    pick_valid_d = pick_valid_q;
    hit_d        = hit_q;
    if (cmd_i.load) begin
      rd_cnt_d     = '0;
      ev_valid_d   = 1'b0;
      best_d       = vcp_pkg::LIFE_MAX;
      pick_d       = '0;
      pick_valid_d = 1'b0;
      hit_d        = 1'b0;
    end else if (cmd_i.scan) begin
      ev_valid_d = rd_en;
      ev_idx_d   = rd_addr;
      ev_vld_d   = vld_q[rd_addr];
      if (rd_en) rd_cnt_d = rd_cnt_q + CW'(1);
      if (ev_valid_q && !hit_q) begin
        if (is_start) begin
          if (start_match) begin
            pick_d       = ev_idx_q;
            pick_valid_d = 1'b1;
            hit_d        = 1'b1;
          end else if (!skip_s && (life_s < best_q)) begin
            best_d       = life_s;
            pick_d       = ev_idx_q;
            pick_valid_d = 1'b1;
          end
        end else if (is_stop && stop_match) begin
          pick_d       = ev_idx_q;
          pick_valid_d = 1'b1;
          hit_d        = 1'b1;
        end
      end
    end
  end

  assign status_o.scan_done = (rd_cnt_q == CW'(VOICES)) && !ev_valid_q;

  // Voice written back for a start or a stop.
  always_comb begin
    new_voice.entity      = item_q.entity;
    new_voice.sub_channel = item_q.sub_channel;
    if (is_start && item_q.playable) begin
      new_voice.active   = 1'b1;
      new_voice.end_time = {1'b0, item_q.now_time} + {8'd0, item_q.sound_length};
    end else begin
      new_voice.active   = 1'b0;
      new_voice.end_time = '0;
    end
  end

  assign wr_en   = cmd_i.write && pick_valid_q && (is_start || is_stop);
  assign wr_data = VW'(new_voice);

  // Per-voice valid bits; clear-all drops them all at once.
  always_comb begin
    vld_d = vld_q;
    if (cmd_i.write) begin
      case (item_q.action)
        vcp_pkg::ACT_START, vcp_pkg::ACT_STOP: begin
          if (pick_valid_q) vld_d[pick_q] = 1'b1;
        end
        vcp_pkg::ACT_CLEAR: begin
          vld_d = '0;
        end
        default: begin
          vld_d = vld_q;
        end
      endcase
    end
  end

  // Result of the finished request.
  assign found_s           = pick_valid_q && (is_start || is_stop);
  assign pick_ext          = IW'(pick_q);
  assign res_s.found       = found_s;
  assign res_s.voice_index = found_s ? pick_ext[2:0] : 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q     <= '0;
      ev_valid_q   <= 1'b0;
      ev_idx_q     <= '0;
      ev_vld_q     <= 1'b0;
      best_q       <= vcp_pkg::LIFE_MAX;
      pick_q       <= '0;
      pick_valid_q <= 1'b0;
      hit_q        <= 1'b0;
      vld_q        <= '0;
      player_q     <= vcp_pkg::PLAYER_RESET;
    end else begin
      rd_cnt_q     <= rd_cnt_d;
      ev_valid_q   <= ev_valid_d;
      ev_idx_q     <= ev_idx_d;
      ev_vld_q     <= ev_vld_d;
      best_q       <= best_d;
      pick_q       <= pick_d;
      pick_valid_q <= pick_valid_d;
      hit_q        <= hit_d;
      vld_q        <= vld_d;
      if (cfg_we_i) player_q <= cfg_data_i;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.emit) out_q <= res_s;
  end

  assign out_data_o = out_q;

  // Voice table storage.
  vcp_ram #(
    .WIDTH (VW),
    .DEPTH (VOICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pick_q),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // The read counter never runs past the table.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= CW'(VOICES))
    else $error("scan counter overran the voice table");

  // A direct match always leaves a chosen voice behind it.
  a_hit_has_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> pick_valid_q)
    else $error("match flag set without a chosen voice");

  // A start that took a voice leaves that voice marked as written.
  a_start_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && is_start && pick_valid_q) |=> vld_q[$past(pick_q)])
    else $error("taken voice not marked valid after write-back");

endmodule

`default_nettype wire

@@ sv/voice_channel_picker.sv @@
// Sound voice allocator over a table of VOICES dynamic voices.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat is a request:
// start a sound, stop a sound, or clear all voices. Output channel
// (out_valid_o / out_ready_i / out_data_o): one beat per request, with found
// and the index of the voice taken or stopped.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
// protected player entity; it is always ready. The user must write it only while
// idle; the block itself does not enforce this. Each request scans the voice
// table once, one voice per cycle through the registered read port of the
// table memory, then writes back the chosen voice, if any; a clear instead
// drops all valid bits. A new request is taken only once the previous one has
// finished; the scan over the single memory read port sets this.
// The result register holds a finished beat while the receiver stalls; the
// next request is still accepted and scanned, and waits for that register
// before its own result is loaded.
// Reset empties the voice table at once (per-voice valid bits) and sets the
// player entity to 1; no clearing pass is needed.
`default_nettype none

module voice_channel_picker #(
  parameter int VOICES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire vcp_pkg::vcp_in_t  in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      vcp_pkg::vcp_out_t out_data_o,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [31:0]       cfg_data_i
);

  vcp_pkg::vcp_cmd_t    cmd;
  vcp_pkg::vcp_status_t status;

  // The register write is always taken.
  assign cfg_ready_o = 1'b1;

  vcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  vcp_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
